// ----- sv/sip_pkg.sv -----
package sip_pkg;

  // mode codes of the func field
  localparam logic FUNC_SEGMENT = 1'b0;
  localparam logic FUNC_LINE    = 1'b1;

  localparam int unsigned OUT_BITS = 32;

  typedef struct packed {
    logic                       hit;
    logic signed [OUT_BITS-1:0] cross_x;
    logic signed [OUT_BITS-1:0] cross_y;
    logic                       clipped;
  } result_t;

endpackage

// ----- sv/segment_intersection_point.sv -----
// segment_intersection_point: crossing point of two 2-d segments or lines
//
// command channel: an item (mode plus eight endpoint coordinates) is taken
//   at a rising edge with start high and busy low
// result channel: valid_o is high for exactly one cycle with hit_o,
//   cross_x_o, cross_y_o and clipped_o; the receiver cannot hold it off
// throughput: one item per cycle, sustained
// pipeline: front stages (differences, products, determinants, classify),
//   a queue register, numerator stages (products, then sums and magnitudes),
//   divider stages (one quotient bit per stage) and a rounding stage
// the front classifies items (parallel, outside the segments) and the back
//   runs the exact division with round half away from zero and saturation
// no hit gives zero coordinates and clipped low
// reset: all valid flags clear at once, nothing is in flight afterwards
// busy only rises if the queue between front and back fills, which it
//   does not, since the back drains it every cycle
module segment_intersection_point import sip_pkg::*; #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic                         func_i,
  input  logic signed [COORD_BITS-1:0] a_start_x_i,
  input  logic signed [COORD_BITS-1:0] a_start_y_i,
  input  logic signed [COORD_BITS-1:0] a_end_x_i,
  input  logic signed [COORD_BITS-1:0] a_end_y_i,
  input  logic signed [COORD_BITS-1:0] b_start_x_i,
  input  logic signed [COORD_BITS-1:0] b_start_y_i,
  input  logic signed [COORD_BITS-1:0] b_end_x_i,
  input  logic signed [COORD_BITS-1:0] b_end_y_i,
  output logic                         valid_o,
  output logic                         hit_o,
  output logic signed [OUT_BITS-1:0]   cross_x_o,
  output logic signed [OUT_BITS-1:0]   cross_y_o,
  output logic                         clipped_o
);

  localparam int unsigned C = COORD_BITS;
  localparam int unsigned D = C + 1;
  localparam int unsigned P = 2 * C + 3;
  // queued item: hit, a start point, a direction, ksi, |delta|
  localparam int unsigned QW = 1 + 2 * C + 2 * D + 2 * P;

  logic                  accept;
  logic                  f_valid, f_hit;
  logic signed [C-1:0]   f_x1, f_y1;
  logic signed [D-1:0]   f_dax, f_day;
  logic signed [P-1:0]   f_ksi;
  logic [P-1:0]          f_den;
  logic [QW-1:0]         q_in, q_out;
  logic                  q_valid, q_full;
  result_t               res;

  assign accept = start && !busy;

  sip_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (accept),
    .func_i      (func_i),
    .a_start_x_i (a_start_x_i),
    .a_start_y_i (a_start_y_i),
    .a_end_x_i   (a_end_x_i),
    .a_end_y_i   (a_end_y_i),
    .b_end_x_i   (b_end_x_i),
    .b_end_y_i   (b_end_y_i),
    .b_start_x_i (b_start_x_i),
    .b_start_y_i (b_start_y_i),
    .valid_o     (f_valid),
    .hit_o       (f_hit),
    .x1_o        (f_x1),
    .y1_o        (f_y1),
    .dax_o       (f_dax),
    .day_o       (f_day),
    .ksi_o       (f_ksi),
    .den_o       (f_den)
  );

  assign q_in = {f_hit, f_x1, f_y1, f_dax, f_day, f_ksi, f_den};

  sip_queue #(.WIDTH(QW)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_valid),
    .data_i  (q_in),
    .pop_i   (1'b1),
    .valid_o (q_valid),
    .full_o  (q_full),
    .data_o  (q_out)
  );

  assign busy = q_full;

  sip_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (q_valid),
    .hit_i    (q_out[QW-1]),
    .x1_i     (q_out[QW-2 -: C]),
    .y1_i     (q_out[QW-2-C -: C]),
    .dax_i    (q_out[QW-2-2*C -: D]),
    .day_i    (q_out[QW-2-2*C-D -: D]),
    .ksi_i    (q_out[2*P-1 -: P]),
    .den_i    (q_out[P-1:0]),
    .valid_o  (valid_o),
    .result_o (res)
  );

  assign hit_o     = res.hit;
  assign cross_x_o = res.cross_x;
  assign cross_y_o = res.cross_y;
  assign clipped_o = res.clipped;

endmodule

// ----- sv/sip_front.sv -----
module sip_front import sip_pkg::*; #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  input  logic                         func_i,
  input  logic signed [COORD_BITS-1:0] a_start_x_i,
  input  logic signed [COORD_BITS-1:0] a_start_y_i,
  input  logic signed [COORD_BITS-1:0] a_end_x_i,
  input  logic signed [COORD_BITS-1:0] a_end_y_i,
  input  logic signed [COORD_BITS-1:0] b_end_x_i,
  input  logic signed [COORD_BITS-1:0] b_end_y_i,
  input  logic signed [COORD_BITS-1:0] b_start_x_i,
  input  logic signed [COORD_BITS-1:0] b_start_y_i,
  output logic                         valid_o,
  output logic                         hit_o,
  output logic signed [COORD_BITS-1:0] x1_o,
  output logic signed [COORD_BITS-1:0] y1_o,
  output logic signed [COORD_BITS:0]   dax_o,
  output logic signed [COORD_BITS:0]   day_o,
  output logic signed [2*COORD_BITS+2:0] ksi_o,
  output logic [2*COORD_BITS+2:0]      den_o
);

  localparam int unsigned C = COORD_BITS;
  localparam int unsigned D = C + 1;
  localparam int unsigned M = 2 * D;
  localparam int unsigned P = 2 * C + 3;

  // stage 1: differences
  logic [3:0] vld_q;
  logic [2:0] func_q;
  logic signed [C-1:0] x1_q [0:2];
  logic signed [C-1:0] y1_q [0:2];
  logic signed [D-1:0] dax_q [0:2];
  logic signed [D-1:0] day_q [0:2];
  logic signed [D-1:0] dbx_q, dby_q, wx_q, wy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    func_q[0] <= func_i;
    x1_q[0]   <= a_start_x_i;
    y1_q[0]   <= a_start_y_i;
    dax_q[0]  <= D'(a_end_x_i) - D'(a_start_x_i);
    day_q[0]  <= D'(a_end_y_i) - D'(a_start_y_i);
    dbx_q     <= D'(b_end_x_i) - D'(b_start_x_i);
    dby_q     <= D'(b_end_y_i) - D'(b_start_y_i);
    wx_q      <= D'(b_end_x_i) - D'(a_start_x_i);
    wy_q      <= D'(b_end_y_i) - D'(a_start_y_i);
  end

  // stage 2: six cross products
  logic signed [M-1:0] p_ad_q, p_bd_q, p_kw_q, p_kv_q, p_ew_q, p_ev_q;

  always_ff @(posedge clk_i) begin
    p_ad_q <= M'(dax_q[0]) * M'(dby_q);
    p_bd_q <= M'(day_q[0]) * M'(dbx_q);
    p_kw_q <= M'(dby_q) * M'(wx_q);
    p_kv_q <= M'(dbx_q) * M'(wy_q);
    p_ew_q <= M'(dax_q[0]) * M'(wy_q);
    p_ev_q <= M'(day_q[0]) * M'(wx_q);
    func_q[1] <= func_q[0];
    x1_q[1]   <= x1_q[0];
    y1_q[1]   <= y1_q[0];
    dax_q[1]  <= dax_q[0];
    day_q[1]  <= day_q[0];
  end

  // stage 3: determinants
  logic signed [P-1:0] delta_q, ksi_q, eta_q;

  always_ff @(posedge clk_i) begin
    delta_q   <= P'(p_ad_q) - P'(p_bd_q);
    ksi_q     <= P'(p_kw_q) - P'(p_kv_q);
    eta_q     <= P'(p_ew_q) - P'(p_ev_q);
    func_q[2] <= func_q[1];
    x1_q[2]   <= x1_q[1];
    y1_q[2]   <= y1_q[1];
    dax_q[2]  <= dax_q[1];
    day_q[2]  <= day_q[1];
  end

  // stage 4: sign normalize and classify
  logic signed [P-1:0] dn, kn, en;
  logic                hit_d;

  always_comb begin
    dn = delta_q[P-1] ? -delta_q : delta_q;
    kn = delta_q[P-1] ? -ksi_q : ksi_q;
    en = delta_q[P-1] ? -eta_q : eta_q;
    hit_d = (delta_q != '0) &&
            ((func_q[2] == FUNC_LINE) ||
             (!kn[P-1] && (kn <= dn) && !en[P-1] && (en <= dn)));
  end

  always_ff @(posedge clk_i) begin
    hit_o <= hit_d;
    x1_o  <= x1_q[2];
    y1_o  <= y1_q[2];
    dax_o <= dax_q[2];
    day_o <= day_q[2];
    ksi_o <= kn;
    den_o <= dn;
  end

  assign valid_o = vld_q[3];

endmodule

// ----- sv/sip_queue.sv -----
module sip_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic             valid_o,
  output logic             full_o,
  output logic [WIDTH-1:0] data_o
);

  logic [WIDTH-1:0] mem_q [0:1];
  logic             wptr_q, rptr_q;
  logic [1:0]       cnt_q;
  logic             do_pop;

  assign do_pop  = pop_i && (cnt_q != 2'd0);
  assign valid_o = cnt_q != 2'd0;
  assign full_o  = cnt_q == 2'd2;
  assign data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wptr_q <= ~wptr_q;
      end
      if (do_pop) begin
        rptr_q <= ~rptr_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

// ----- sv/sip_back.sv -----
module sip_back import sip_pkg::*; #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  input  logic                           hit_i,
  input  logic signed [COORD_BITS-1:0]   x1_i,
  input  logic signed [COORD_BITS-1:0]   y1_i,
  input  logic signed [COORD_BITS:0]     dax_i,
  input  logic signed [COORD_BITS:0]     day_i,
  input  logic signed [2*COORD_BITS+2:0] ksi_i,
  input  logic [2*COORD_BITS+2:0]        den_i,
  output logic                           valid_o,
  output result_t                        result_o
);

  localparam int unsigned C  = COORD_BITS;
  localparam int unsigned P  = 2 * C + 3;
  localparam int unsigned N  = C + P + 2;
  localparam int unsigned QW = (N + 1 > OUT_BITS + 1) ? N + 1 : OUT_BITS + 1;

  // numerator products
  logic                v1_q, v2_q;
  logic                h1_q, h2_q;
  logic [P-1:0]        d1_q;
  logic signed [N-1:0] bx_q, by_q, kx_q, ky_q;
  logic signed [P:0]   den_s;

  assign den_s = $signed({1'b0, den_i});

  always_ff @(posedge clk_i) begin
    bx_q <= N'(x1_i) * N'(den_s);
    by_q <= N'(y1_i) * N'(den_s);
    kx_q <= N'(ksi_i) * N'(dax_i);
    ky_q <= N'(ksi_i) * N'(day_i);
    h1_q <= hit_i;
    d1_q <= den_i;
  end

  // sums and magnitudes
  logic signed [N-1:0] tx, ty;
  logic [N-1:0]        nx0_q, ny0_q;
  logic                sx0_q, sy0_q;
  logic [P-1:0]        d2_q;

  assign tx = bx_q + kx_q;
  assign ty = by_q + ky_q;

  always_ff @(posedge clk_i) begin
    nx0_q <= tx[N-1] ? N'(-tx) : N'(tx);
    ny0_q <= ty[N-1] ? N'(-ty) : N'(ty);
    sx0_q <= tx[N-1];
    sy0_q <= ty[N-1];
    h2_q  <= h1_q;
    d2_q  <= d1_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  // restoring divider, one quotient bit per stage for both coordinates
  logic [N:0]   vs_q;
  logic [N-1:0] nx_q [0:N];
  logic [N-1:0] ny_q [0:N];
  logic [N-1:0] qx_q [0:N];
  logic [N-1:0] qy_q [0:N];
  logic [P-1:0] rx_q [0:N];
  logic [P-1:0] ry_q [0:N];
  logic [P-1:0] dv_q [0:N];
  logic         sx_q [0:N];
  logic         sy_q [0:N];
  logic         hs_q [0:N];

  assign nx_q[0] = nx0_q;
  assign ny_q[0] = ny0_q;
  assign qx_q[0] = '0;
  assign qy_q[0] = '0;
  assign rx_q[0] = '0;
  assign ry_q[0] = '0;
  assign dv_q[0] = d2_q;
  assign sx_q[0] = sx0_q;
  assign sy_q[0] = sy0_q;
  assign hs_q[0] = h2_q;
  assign vs_q[0] = v2_q;

  for (genvar k = 0; k < N; k++) begin : g_div
    logic [P:0] trx, try_, subx, suby;
    logic       gex, gey;

    assign trx  = {rx_q[k], nx_q[k][N-1]};
    assign try_ = {ry_q[k], ny_q[k][N-1]};
    assign subx = trx - {1'b0, dv_q[k]};
    assign suby = try_ - {1'b0, dv_q[k]};
    assign gex  = trx >= {1'b0, dv_q[k]};
    assign gey  = try_ >= {1'b0, dv_q[k]};

    always_ff @(posedge clk_i) begin
      rx_q[k+1] <= gex ? subx[P-1:0] : trx[P-1:0];
      ry_q[k+1] <= gey ? suby[P-1:0] : try_[P-1:0];
      nx_q[k+1] <= nx_q[k] << 1;
      ny_q[k+1] <= ny_q[k] << 1;
      qx_q[k+1] <= {qx_q[k][N-2:0], gex};
      qy_q[k+1] <= {qy_q[k][N-2:0], gey};
      dv_q[k+1] <= dv_q[k];
      sx_q[k+1] <= sx_q[k];
      sy_q[k+1] <= sy_q[k];
      hs_q[k+1] <= hs_q[k];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vs_q[k+1] <= 1'b0;
      end else begin
        vs_q[k+1] <= vs_q[k];
      end
    end
  end

  // round half away from zero, then saturate
  logic [QW-1:0]       rqx, rqy, limx, limy;
  logic                clx, cly;
  logic [OUT_BITS-1:0] mx, my;
  result_t             res_d;

  always_comb begin
    rqx  = QW'(qx_q[N]) + QW'({rx_q[N], 1'b0} >= {1'b0, dv_q[N]});
    rqy  = QW'(qy_q[N]) + QW'({ry_q[N], 1'b0} >= {1'b0, dv_q[N]});
    limx = sx_q[N] ? (QW'(1) << (OUT_BITS - 1)) : ((QW'(1) << (OUT_BITS - 1)) - QW'(1));
    limy = sy_q[N] ? (QW'(1) << (OUT_BITS - 1)) : ((QW'(1) << (OUT_BITS - 1)) - QW'(1));
    clx  = rqx > limx;
    cly  = rqy > limy;
    mx   = clx ? limx[OUT_BITS-1:0] : rqx[OUT_BITS-1:0];
    my   = cly ? limy[OUT_BITS-1:0] : rqy[OUT_BITS-1:0];
    res_d.hit     = hs_q[N];
    res_d.cross_x = hs_q[N] ? (sx_q[N] ? -mx : mx) : '0;
    res_d.cross_y = hs_q[N] ? (sy_q[N] ? -my : my) : '0;
    res_d.clipped = hs_q[N] && (clx || cly);
  end

  always_ff @(posedge clk_i) begin
    result_o <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= vs_q[N];
    end
  end

endmodule

// ----- test/segment_intersection_point_tb.sv -----
`timescale 1ns / 1ps

module segment_intersection_point_tb;
  import sip_pkg::*;

  localparam int unsigned CB = 16;
  localparam int unsigned N_RANDOM = 1930;
  localparam int unsigned CALM_TAIL = 200;    // no idling in the last items
  localparam int unsigned DRAIN_CYCLES = 3 * CB + 30;
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef logic signed [CB-1:0] coord_t;

  // one item: mode plus both segments
  typedef struct packed {
    logic   func;
    coord_t ax0, ay0, ax1, ay1;
    coord_t bx0, by0, bx1, by1;
  } seg_pair_t;

  typedef struct packed {
    seg_pair_t pair;
    logic      typed;     // expectation written in the table
    result_t   res;
  } row_t;

  // random item shapes
  typedef enum logic [2:0] {
    SHAPE_WIDE, SHAPE_TINY, SHAPE_SKEW, SHAPE_PARALLEL, SHAPE_EDGE
  } shape_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  seg_pair_t drv = '0;
  logic drv_typed = 1'b0;
  result_t drv_res = '0;

  logic valid_o, hit_o, clipped_o;
  logic signed [OUT_BITS-1:0] cross_x_o, cross_y_o;

  result_t crossing_q[$];
  int unsigned mismatches = 0;
  int unsigned n_items = 0, n_hits = 0, n_clipped = 0, n_results = 0;
  int unsigned cycles = 0;

  always #4 clk_i = ~clk_i;

  segment_intersection_point #(.COORD_BITS(CB)) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .func_i     (drv.func),
    .a_start_x_i(drv.ax0),
    .a_start_y_i(drv.ay0),
    .a_end_x_i  (drv.ax1),
    .a_end_y_i  (drv.ay1),
    .b_start_x_i(drv.bx0),
    .b_start_y_i(drv.by0),
    .b_end_x_i  (drv.bx1),
    .b_end_y_i  (drv.by1),
    .valid_o    (valid_o),
    .hit_o      (hit_o),
    .cross_x_o  (cross_x_o),
    .cross_y_o  (cross_y_o),
    .clipped_o  (clipped_o)
  );

  // rounds (base*den + k*d)/den half away from zero, saturating to 32 bits
  function automatic logic signed [31:0] round_coord(input longint base, input longint k,
                                                     input longint d, input longint den,
                                                     inout logic clip);
    logic signed [127:0] b, kk, dd, dn, t;
    logic [127:0] num, q, r, limit;
    logic neg;
    b = base;
    kk = k;
    dd = d;
    dn = den;
    t = b * dn + kk * dd;
    neg = t < 0;
    num = neg ? -t : t;
    q = num / dn;
    r = num % dn;
    if (2 * r >= dn) q = q + 1;
    limit = neg ? 128'h8000_0000 : 128'h7fff_ffff;
    if (q > limit) begin
      clip = 1'b1;
      q = limit;
    end
    return neg ? -q[31:0] : q[31:0];
  endfunction

  // expected result of one pair: exact integer classification, then rounding
  function automatic result_t crossing_point(input seg_pair_t p);
    longint dax, day, dbx, dby, wx, wy, delta, ksi, eta;
    logic hit, clip;
    result_t res;
    dax = longint'(p.ax1) - longint'(p.ax0);
    day = longint'(p.ay1) - longint'(p.ay0);
    dbx = longint'(p.bx1) - longint'(p.bx0);
    dby = longint'(p.by1) - longint'(p.by0);
    wx = longint'(p.bx1) - longint'(p.ax0);
    wy = longint'(p.by1) - longint'(p.ay0);
    delta = dax * dby - day * dbx;
    ksi = dby * wx - dbx * wy;
    eta = dax * wy - day * wx;
    hit = delta != 0;
    clip = 1'b0;
    res = '0;
    if (delta < 0) begin
      delta = -delta;
      ksi = -ksi;
      eta = -eta;
    end
    // bounded mode keeps only crossings inside both segments, ends included
    if (hit && p.func == FUNC_SEGMENT &&
        (ksi < 0 || ksi > delta || eta < 0 || eta > delta)) hit = 1'b0;
    if (!hit) return res;
    res.hit = 1'b1;
    res.cross_x = round_coord(longint'(p.ax0), ksi, dax, delta, clip);
    res.cross_y = round_coord(longint'(p.ay0), ksi, day, delta, clip);
    res.clipped = clip;
    return res;
  endfunction

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s at cycle %0d: got %0d, expected %0d", what, cycles, got, want);
    mismatches++;
  endtask

  // takes items at the edge and checks results against the oldest expectation;
  // outputs and inputs are read here before any update of this edge lands
  always @(posedge clk_i) begin
    result_t want;
    cycles <= cycles + 1;
    if (rst_ni && start && !busy) begin
      crossing_q.push_back(drv_typed ? drv_res : crossing_point(drv));
      n_items++;
    end
    if (rst_ni && valid_o) begin
      n_results++;
      if (crossing_q.size() == 0) begin
        report("result with nothing pending", 1, 0);
      end else begin
        want = crossing_q.pop_front();
        if (hit_o !== want.hit) report("hit", hit_o, want.hit);
        if (cross_x_o !== want.cross_x) report("cross_x", cross_x_o, want.cross_x);
        if (cross_y_o !== want.cross_y) report("cross_y", cross_y_o, want.cross_y);
        if (clipped_o !== want.clipped) report("clipped", clipped_o, want.clipped);
        if (want.hit) n_hits++;
        if (want.clipped) n_clipped++;
      end
    end
  end

  // hard stop if the block hangs
  always @(posedge clk_i) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // holds the item on the ports until the block takes it
  task automatic send_item(input seg_pair_t p, input logic typed, input result_t res);
    start <= 1'b1;
    drv <= p;
    drv_typed <= typed;
    drv_res <= res;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic idle_gap(input int unsigned n);
    start <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  function automatic seg_pair_t mk(input logic f, input int ax0, input int ay0,
                                   input int ax1, input int ay1, input int bx0,
                                   input int by0, input int bx1, input int by1);
    seg_pair_t p;
    p.func = f;
    p.ax0 = coord_t'(ax0); p.ay0 = coord_t'(ay0);
    p.ax1 = coord_t'(ax1); p.ay1 = coord_t'(ay1);
    p.bx0 = coord_t'(bx0); p.by0 = coord_t'(by0);
    p.bx1 = coord_t'(bx1); p.by1 = coord_t'(by1);
    return p;
  endfunction

  function automatic int rnd(input int lo, input int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  // random pair of the given shape; mode is random throughout
  function automatic seg_pair_t random_pair(input shape_e s);
    int ax0, ay0, dx, dy, bx0, by0, k;
    logic f;
    f = 1'($urandom_range(1));
    case (s)
      SHAPE_WIDE: begin
        return mk(f, rnd(-32768, 32767), rnd(-32768, 32767), rnd(-32768, 32767),
                  rnd(-32768, 32767), rnd(-32768, 32767), rnd(-32768, 32767),
                  rnd(-32768, 32767), rnd(-32768, 32767));
      end
      SHAPE_TINY: begin
        // dense grid: many hits, end touches and half-way ties
        return mk(f, rnd(-6, 6), rnd(-6, 6), rnd(-6, 6), rnd(-6, 6),
                  rnd(-6, 6), rnd(-6, 6), rnd(-6, 6), rnd(-6, 6));
      end
      SHAPE_SKEW: begin
        // almost parallel lines meet far away, which drives saturation
        ax0 = rnd(-32768, 32767); ay0 = rnd(-32768, 32767);
        dx = rnd(-32767, 32767); dy = rnd(-32767, 32767);
        bx0 = rnd(-32768, 32767); by0 = rnd(-32768, 32767);
        return mk(f, ax0, ay0, ax0 + dx, ay0 + dy, bx0, by0,
                  bx0 + dx + rnd(-2, 2), by0 + dy + rnd(-2, 2));
      end
      SHAPE_PARALLEL: begin
        ax0 = rnd(-1000, 1000); ay0 = rnd(-1000, 1000);
        dx = rnd(-50, 50); dy = rnd(-50, 50); k = rnd(-3, 3);
        bx0 = ax0 + rnd(-100, 100); by0 = ay0 + rnd(-100, 100);
        return mk(f, ax0, ay0, ax0 + dx, ay0 + dy, bx0, by0, bx0 + k * dx, by0 + k * dy);
      end
      default: begin
        // corners of the coordinate range
        return mk(f, $urandom_range(1) ? -32768 : 32767, $urandom_range(1) ? -32768 : 32767,
                  $urandom_range(1) ? -32768 : 32767, $urandom_range(1) ? -32768 : 32767,
                  $urandom_range(1) ? -32768 : 32767, $urandom_range(1) ? -32768 : 32767,
                  $urandom_range(1) ? -32768 : 32767, $urandom_range(1) ? -32768 : 32767);
      end
    endcase
  endfunction

  localparam result_t NO_HIT = '0;

  row_t directed[$];

  initial begin
    shape_e s;
    int unsigned r;

    // directed table; rows marked typed carry an obvious expectation
    directed.push_back('{mk(FUNC_SEGMENT, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, NO_HIT});
    directed.push_back('{mk(FUNC_SEGMENT, 0, 0, 2, 2, 0, 2, 2, 0), 1'b1,
                         result_t'{1'b1, 32'sd1, 32'sd1, 1'b0}});
    directed.push_back('{mk(FUNC_LINE, 0, 0, 2, 2, 0, 2, 2, 0), 1'b1,
                         result_t'{1'b1, 32'sd1, 32'sd1, 1'b0}});
    // lines meet at (1.5,1.5), outside segment a
    directed.push_back('{mk(FUNC_SEGMENT, 0, 0, 1, 1, 3, 0, 2, 1), 1'b1, NO_HIT});
    directed.push_back('{mk(FUNC_LINE, 0, 0, 1, 1, 3, 0, 2, 1), 1'b1,
                         result_t'{1'b1, 32'sd2, 32'sd2, 1'b0}});
    // touching at an end counts as a hit
    directed.push_back('{mk(FUNC_SEGMENT, 0, 0, 2, 0, 2, 0, 2, 5), 1'b1,
                         result_t'{1'b1, 32'sd2, 32'sd0, 1'b0}});
    // ties at one half round away from zero
    directed.push_back('{mk(FUNC_SEGMENT, 0, 0, -1, 0, -1, 1, 0, -1), 1'b1,
                         result_t'{1'b1, -32'sd1, 32'sd0, 1'b0}});
    directed.push_back('{mk(FUNC_SEGMENT, 0, 0, 1, 0, 1, 1, 0, -1), 1'b1,
                         result_t'{1'b1, 32'sd1, 32'sd0, 1'b0}});
    // parallel, degenerate and collinear pairs never hit
    directed.push_back('{mk(FUNC_LINE, 0, 0, 1, 1, 0, 1, 1, 2), 1'b1, NO_HIT});
    directed.push_back('{mk(FUNC_LINE, 5, 5, 5, 5, -3, 7, 9, -2), 1'b1, NO_HIT});
    directed.push_back('{mk(FUNC_SEGMENT, 0, 0, 4, 0, 2, 0, 6, 0), 1'b1, NO_HIT});
    directed.push_back('{mk(FUNC_LINE, -32768, -32768, -32768, -32768, -32768, -32768,
                            -32768, -32768), 1'b1, NO_HIT});
    directed.push_back('{mk(FUNC_SEGMENT, 32767, 32767, 32767, 32767, 32767, 32767,
                            32767, 32767), 1'b1, NO_HIT});
    // full-range diagonals
    directed.push_back('{mk(FUNC_SEGMENT, -32768, -32768, 32767, 32767, -32768, 32767,
                            32767, -32768), 1'b0, NO_HIT});
    directed.push_back('{mk(FUNC_LINE, -32768, -32768, 32767, 32767, -32768, 32767,
                            32767, -32768), 1'b0, NO_HIT});
    // nearly parallel, far crossing
    directed.push_back('{mk(FUNC_LINE, -32768, -32768, -1, -2, 0, 0, 32766, 32765),
                         1'b0, NO_HIT});
    directed.push_back('{mk(FUNC_LINE, -32768, 32767, 32767, -32768, 32767, -32767,
                            -32768, 32766), 1'b0, NO_HIT});
    directed.push_back('{mk(FUNC_SEGMENT, -32768, 32767, 32767, -32768, 32767, -32767,
                            -32768, 32766), 1'b0, NO_HIT});

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) send_item(directed[i].pair, directed[i].typed, directed[i].res);

    for (r = 0; r < N_RANDOM; r++) begin
      // sender holds off until the pipeline has fully drained, once
      if (r == N_RANDOM / 2) begin
        start <= 1'b0;
        while (crossing_q.size() != 0) @(posedge clk_i);
      end
      case ($urandom_range(9))
        0, 1, 2: s = SHAPE_WIDE;
        3, 4, 5: s = SHAPE_TINY;
        6, 7:    s = SHAPE_SKEW;
        8:       s = SHAPE_PARALLEL;
        default: s = SHAPE_EDGE;
      endcase
      send_item(random_pair(s), 1'b0, NO_HIT);
      // idle bursts, some stretches back to back, none near the end
      if (r < N_RANDOM - CALM_TAIL && ((r / 64) % 3 != 0) && $urandom_range(5) == 0)
        idle_gap($urandom_range(16, 1));
    end
    start <= 1'b0;

    while (crossing_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("%0d items, %0d results: %0d crossings found, %0d saturated",
             n_items, n_results, n_hits, n_clipped);
    if (mismatches == 0 && crossing_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
